[hw/rtl/sctd_pkg.sv]
// Shared types, constants and lookup functions for the sine/cosine Taylor core.
// Used by every module of the block; depends on nothing.
package sctd_pkg;

  localparam int MAX_TERMS = 8;
  localparam int FRAC_BITS = 30;

  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 32;
  localparam int COUNT_W = 5;
  localparam int TERM_W  = $clog2(MAX_TERMS);
  localparam int Q_W     = 31;
  localparam int H_W     = 29;
  localparam int ACC_W   = 36;

  localparam logic [Q_W-1:0] Q_ONE       = 31'h4000_0000;
  localparam logic [Q_W-1:0] EPS_Q       = 31'd1074;
  localparam logic [24:0]    DEG_TO_RAD  = 25'd18740330;
  localparam logic [16:0]    ANGLE_BIAS  = 17'd33120;   // 92 * 360
  localparam logic [17:0]    MOD_RECIP   = 18'd186413;  // floor(2^26 / 360)
  localparam int             MOD_SHIFT   = 26;
  localparam int             RECIP_SHIFT = 32;

  typedef struct packed {
    logic                    w;
    logic                    neg_out;
    logic                    hneg;
    logic [H_W-1:0]          hmag;
    logic [Q_W-1:0]          dsin;
    logic [Q_W-1:0]          dcos;
    logic [Q_W-1:0]          tmag;
    logic                    tneg;
    logic signed [ACC_W-1:0] acc;
    logic [COUNT_W-1:0]      count;
    logic                    done;
  } ctx_t;

  // sine of the anchor angles 0, 30, 45, 60, 90 in Q30
  function automatic logic [Q_W-1:0] anchor_sin(input logic [2:0] idx);
    logic [Q_W-1:0] v;
    case (idx)
      3'd0:    v = 31'd0;
      3'd1:    v = 31'd536870912;
      3'd2:    v = 31'd759250125;
      3'd3:    v = 31'd929887697;
      3'd4:    v = 31'd1073741824;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] anchor_deg(input logic [2:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd30;
      3'd2:    v = 7'd45;
      3'd3:    v = 7'd60;
      3'd4:    v = 7'd90;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // floor(2^32 / m) for the constant divide in each series term
  function automatic logic [32:0] term_recip(input logic [TERM_W-1:0] m);
    logic [32:0] v;
    case (4'(m))
      4'd1:    v = 33'd4294967296;
      4'd2:    v = 33'd2147483648;
      4'd3:    v = 33'd1431655765;
      4'd4:    v = 33'd1073741824;
      4'd5:    v = 33'd858993459;
      4'd6:    v = 33'd715827882;
      4'd7:    v = 33'd613566756;
      4'd8:    v = 33'd536870912;
      4'd9:    v = 33'd477218588;
      4'd10:   v = 33'd429496729;
      4'd11:   v = 33'd390451572;
      4'd12:   v = 33'd357913941;
      4'd13:   v = 33'd330382099;
      4'd14:   v = 33'd306783378;
      4'd15:   v = 33'd286331153;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/sctd_front.sv]
// Front end: angle reduction modulo 360, quadrant fold, anchor pick and
// term-zero setup, three register stages. Depends on sctd_pkg.
module sctd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [sctd_pkg::ANGLE_W-1:0] angle_i,
  input  logic                                wave_i,
  output logic                                valid_o,
  output sctd_pkg::ctx_t                      ctx_o
);

  // stage 1: biased angle times reciprocal of 360
  logic [16:0] u_d;
  logic [34:0] mq_d;
  logic        v1_q, w1_q;
  logic [16:0] u_q;
  logic [34:0] mq_q;

  assign u_d  = 17'({angle_i[sctd_pkg::ANGLE_W-1], angle_i}) + sctd_pkg::ANGLE_BIAS;
  assign mq_d = 35'(u_d) * 35'(sctd_pkg::MOD_RECIP);

  // stage 2: remainder, quadrant sign and fold
  logic [7:0]  q0;
  logic [16:0] qm;
  logic [9:0]  y0;
  logic [8:0]  y;
  logic [6:0]  x_d;
  logic        neg_d;
  logic        v2_q, w2_q, neg2_q;
  logic [6:0]  x_q;

  always_comb begin
    q0 = 8'(mq_q >> sctd_pkg::MOD_SHIFT);
    qm = 17'(q0) * 17'd360;
    y0 = 10'(u_q - qm);
    // quotient estimate may be one short
    y  = (y0 >= 10'd360) ? 9'(y0 - 10'd360) : 9'(y0);
    if (!w1_q) begin
      neg_d = (y > 9'd180);
    end else begin
      neg_d = (y > 9'd90) && (y < 9'd270);
    end
    if (y < 9'd90) begin
      x_d = 7'(y);
    end else if (y < 9'd180) begin
      x_d = 7'(9'd180 - y);
    end else if (y < 9'd270) begin
      x_d = 7'(y - 9'd180);
    end else begin
      x_d = 7'(9'd360 - y);
    end
  end

  // stage 3: nearest anchor (ties go up), offset in radians, term zero
  logic [2:0]       idx;
  logic signed [7:0] off;
  logic [3:0]       off_mag;
  sctd_pkg::ctx_t   ctx_d;
  logic             v3_q;
  sctd_pkg::ctx_t   ctx3_q;

  always_comb begin
    if (x_q < 7'd15) begin
      idx = 3'd0;
    end else if (x_q < 7'd38) begin
      idx = 3'd1;
    end else if (x_q < 7'd53) begin
      idx = 3'd2;
    end else if (x_q < 7'd75) begin
      idx = 3'd3;
    end else begin
      idx = 3'd4;
    end
    off     = $signed({1'b0, x_q}) - $signed({1'b0, sctd_pkg::anchor_deg(idx)});
    off_mag = off[7] ? 4'(-off) : 4'(off);

    ctx_d.w       = w2_q;
    ctx_d.neg_out = neg2_q;
    ctx_d.hneg    = off[7];
    ctx_d.hmag    = sctd_pkg::H_W'(29'(off_mag) * 29'(sctd_pkg::DEG_TO_RAD));
    ctx_d.dsin    = sctd_pkg::anchor_sin(idx);
    ctx_d.dcos    = sctd_pkg::anchor_sin(3'(3'd4 - idx));
    ctx_d.tmag    = sctd_pkg::Q_ONE;
    ctx_d.tneg    = 1'b0;
    ctx_d.acc     = sctd_pkg::ACC_W'(w2_q ? ctx_d.dcos : ctx_d.dsin);
    ctx_d.count   = sctd_pkg::COUNT_W'(1);
    ctx_d.done    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_d;
      mq_q   <= mq_d;
      w1_q   <= wave_i;
      x_q    <= x_d;
      neg2_q <= neg_d;
      w2_q   <= w1_q;
      ctx3_q <= ctx_d;
    end
  end

  assign valid_o = v3_q;
  assign ctx_o   = ctx3_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> x_q <= 7'd90)
    else $error("folded angle outside first quadrant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ctx_o.hmag <= sctd_pkg::H_W'(29'd15 * 29'(sctd_pkg::DEG_TO_RAD)))
    else $error("anchor offset exceeds 15 degrees");
`endif

endmodule

[hw/rtl/sctd_term.sv]
// One Taylor series term: power update, constant divide by the term index,
// derivative product and accumulate, five register stages. Depends on sctd_pkg.
module sctd_term (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [sctd_pkg::TERM_W-1:0]   term_idx_i,
  input  logic                          valid_i,
  input  sctd_pkg::ctx_t                ctx_i,
  output logic                          valid_o,
  output sctd_pkg::ctx_t                ctx_o
);

  localparam logic [61:0] HalfQ = 62'd1 << 29;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  sctd_pkg::ctx_t ctx1_q, ctx2_q, ctx3_q, ctx4_q, ctx5_q;

  // stage 1: previous power times offset
  sctd_pkg::ctx_t ctx1_d;
  logic [59:0]    p1_d, p1_q;

  always_comb begin
    ctx1_d      = ctx_i;
    ctx1_d.tneg = ctx_i.tneg ^ ctx_i.hneg;
  end
  assign p1_d = 60'(ctx_i.tmag) * 60'(ctx_i.hmag);

  // stage 2: round, add half the divisor, multiply by its reciprocal
  logic [29:0] n2_d, n2_q;
  logic [62:0] qp2_d, qp2_q;

  assign n2_d  = 30'((62'(p1_q) + HalfQ) >> 30) + 30'(term_idx_i >> 1);
  assign qp2_d = 63'(n2_d) * 63'(sctd_pkg::term_recip(term_idx_i));

  // stage 3: fix the quotient estimate, which may be one short
  logic [29:0]    q0, r3, t3;
  sctd_pkg::ctx_t ctx3_d;

  always_comb begin
    q0 = 30'(qp2_q >> sctd_pkg::RECIP_SHIFT);
    r3 = n2_q - 30'(q0 * 30'(term_idx_i));
    t3 = (r3 >= 30'(term_idx_i)) ? q0 + 30'd1 : q0;
    ctx3_d      = ctx2_q;
    ctx3_d.tmag = sctd_pkg::Q_W'(t3);
  end

  // stage 4: derivative at the anchor times the power term
  logic [1:0]  ph;
  logic [30:0] dv;
  logic [61:0] pr4_d, pr4_q;
  logic        sub4_d, sub4_q;

  always_comb begin
    ph     = 2'(term_idx_i) + {1'b0, ctx3_q.w};
    dv     = ph[0] ? ctx3_q.dcos : ctx3_q.dsin;
    pr4_d  = 62'(dv) * 62'(ctx3_q.tmag);
    sub4_d = ph[1] ^ ctx3_q.tneg;
  end

  // stage 5: accumulate unless an earlier term already converged
  logic [30:0]    prod5;
  sctd_pkg::ctx_t ctx5_d;

  always_comb begin
    prod5  = 31'((pr4_q + HalfQ) >> 30);
    ctx5_d = ctx4_q;
    if (!ctx4_q.done) begin
      ctx5_d.acc   = sub4_q ? ctx4_q.acc - sctd_pkg::ACC_W'(prod5)
                            : ctx4_q.acc + sctd_pkg::ACC_W'(prod5);
      ctx5_d.count = ctx4_q.count + sctd_pkg::COUNT_W'(1);
      ctx5_d.done  = (ctx4_q.tmag <= sctd_pkg::EPS_Q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q <= ctx1_d;
      p1_q   <= p1_d;
      ctx2_q <= ctx1_q;
      n2_q   <= n2_d;
      qp2_q  <= qp2_d;
      ctx3_q <= ctx3_d;
      ctx4_q <= ctx3_q;
      pr4_q  <= pr4_d;
      sub4_q <= sub4_d;
      ctx5_q <= ctx5_d;
    end
  end

  assign valid_o = v5_q;
  assign ctx_o   = ctx5_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ctx_o.count != '0) &&
                (ctx_o.count <= sctd_pkg::COUNT_W'(term_idx_i) + sctd_pkg::COUNT_W'(1)))
    else $error("term count beyond terms passed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ctx_o.done |->
      ctx_o.count == sctd_pkg::COUNT_W'(term_idx_i) + sctd_pkg::COUNT_W'(1))
    else $error("term skipped without convergence");
`endif

endmodule

[hw/rtl/sctd_back.sv]
// Output stage: saturate the series sum, apply the quadrant sign, scale to
// the output format and hold the result register. Depends on sctd_pkg.
module sctd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  sctd_pkg::ctx_t                     ctx_i,
  output logic                               valid_o,
  output logic signed [sctd_pkg::TRIG_W-1:0] trig_o,
  output logic [sctd_pkg::COUNT_W-1:0]       terms_o
);

  localparam int ShiftL = (sctd_pkg::FRAC_BITS >= 30) ? sctd_pkg::FRAC_BITS - 30 : 0;
  localparam int ShiftR = (sctd_pkg::FRAC_BITS < 30) ? 30 - sctd_pkg::FRAC_BITS : 0;
  localparam logic [63:0] RoundAdd = (64'd1 << ShiftR) >> 1;
  localparam logic signed [sctd_pkg::ACC_W-1:0] AccOne = sctd_pkg::ACC_W'(sctd_pkg::Q_ONE);

  logic signed [sctd_pkg::ACC_W-1:0] sat;
  logic [30:0]                       mag;
  logic                              neg;
  logic [63:0]                       rmag, res;

  always_comb begin
    if (ctx_i.acc > AccOne) begin
      sat = AccOne;
    end else if (ctx_i.acc < -AccOne) begin
      sat = -AccOne;
    end else begin
      sat = ctx_i.acc;
    end
    neg  = ctx_i.neg_out ^ sat[sctd_pkg::ACC_W-1];
    mag  = sat[sctd_pkg::ACC_W-1] ? 31'(-sat) : 31'(sat);
    rmag = ((64'(mag) << ShiftL) + RoundAdd) >> ShiftR;
    res  = neg ? 64'(0) - rmag : rmag;
  end

  logic                               v_q;
  logic signed [sctd_pkg::TRIG_W-1:0] trig_q;
  logic [sctd_pkg::COUNT_W-1:0]       terms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q  <= res[sctd_pkg::TRIG_W-1:0];
      terms_q <= ctx_i.count;
    end
  end

  assign valid_o = v_q;
  assign trig_o  = trig_q;
  assign terms_o = terms_q;

endmodule

[hw/rtl/sin_cos_taylor_degrees_core.sv]
// Top level of the whole-degree sine/cosine unit: mode register, front end,
// chain of series terms and output stage. Depends on sctd_pkg and all sctd_ modules.
//
//  channel   direction  signals                          transfer
//  in        input      in_valid_i / in_ready_o          angle_degrees_i
//  out       output     out_valid_o / out_ready_i        trig_value_o, terms_used_o
//  cfg       input      cfg_we_i                         cfg_wdata_i (0 sine, 1 cosine)
//
// One request enters per cycle while the output is not stalled; the pipeline has
// three front stages, five per series term and one output stage.
// Reset clears all valid bits and selects sine.
// The whole pipeline advances together whenever the output register is empty or
// being taken; a stall at the output holds every stage and the input.
module sin_cos_taylor_degrees_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sctd_pkg::ANGLE_W-1:0] angle_degrees_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sctd_pkg::TRIG_W-1:0]  trig_value_o,
  output logic [sctd_pkg::COUNT_W-1:0]        terms_used_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i
);

  logic wave_select_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_select_q <= 1'b0;
    end else if (cfg_we_i) begin
      wave_select_q <= cfg_wdata_i;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic           valid_w [sctd_pkg::MAX_TERMS];
  sctd_pkg::ctx_t ctx_w   [sctd_pkg::MAX_TERMS];

  sctd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (angle_degrees_i),
    .wave_i  (wave_select_q),
    .valid_o (valid_w[0]),
    .ctx_o   (ctx_w[0])
  );

  for (genvar k = 1; k < sctd_pkg::MAX_TERMS; k++) begin : g_term
    sctd_term u_term (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .term_idx_i (sctd_pkg::TERM_W'(k)),
      .valid_i    (valid_w[k-1]),
      .ctx_i      (ctx_w[k-1]),
      .valid_o    (valid_w[k]),
      .ctx_o      (ctx_w[k])
    );
  end

  sctd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_w[sctd_pkg::MAX_TERMS-1]),
    .ctx_i   (ctx_w[sctd_pkg::MAX_TERMS-1]),
    .valid_o (out_valid_o),
    .trig_o  (trig_value_o),
    .terms_o (terms_used_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (terms_used_o != '0) &&
                    (terms_used_o <= sctd_pkg::COUNT_W'(sctd_pkg::MAX_TERMS)))
    else $error("terms_used out of range");
`endif

endmodule
